/* hdl/sliding_window_event_counter_unit_macros.svh */
// Assertion macros for the sliding window event counter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SLIDING_WINDOW_EVENT_COUNTER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWEC_AST_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("swec check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWEC_AST_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("swec check failed");

`endif

/* hdl/swec_pkg.sv */
// Shared types and constants for the sliding window event counter.
// No dependencies.
`timescale 1ns / 1ps

package swec_pkg;

  localparam int TIME_W = 32;
  localparam int CNT_W  = 7;

  typedef struct packed {
    logic              lt;
    logic [TIME_W-1:0] val;
  } swec_nbr_t;

endpackage

/* hdl/swec_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on swec_pkg.
`timescale 1ns / 1ps

interface swec_in_if import swec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] event_time;
  logic [TIME_W-1:0] now_seconds;
  logic [TIME_W-1:0] window_seconds;

  modport source (output valid, req_type, event_time, now_seconds, window_seconds,
                  input ready);
  modport sink (input valid, req_type, event_time, now_seconds, window_seconds,
                output ready);
endinterface

interface swec_out_if import swec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  count_in_window;
  logic              dropped_oldest;
  logic [CNT_W-1:0]  stored_entries;
  logic [TIME_W-1:0] records_total;
  logic [TIME_W-1:0] queries_total;

  modport source (output valid, count_in_window, dropped_oldest, stored_entries,
                  records_total, queries_total, input ready);
  modport sink (input valid, count_in_window, dropped_oldest, stored_entries,
                records_total, queries_total, output ready);
endinterface

/* hdl/sliding_window_event_counter_unit.sv */
// Sliding window event counter: request channel in_ch, result channel out_ch.
// Each request beat either records a timestamp (req_type 0; a zero event_time
// takes now_seconds) or queries how many stored timestamps lie at or after
// now_seconds - window_seconds, wrapping modulo 2^32. Every request yields
// exactly one result beat carrying the window count, an eviction flag, the
// fill level and the running record and query totals.
// Timestamps sit in a row of DEPTH cells kept in ascending order. In the
// accept cycle every cell compares its entry with the key; at a record's
// update each cell takes its own, its neighbor's or the new value. The query
// position comes from the one cell where the compare flags change, or from
// the tail flag when all are set. A result is loaded into the output register
// when its update fires. A new request is not taken until that update; the
// compare-then-shift pass of the cell row sets that. A result may wait in the
// output register while the next request is accepted; if it is still not
// taken when the following update is due, the row holds until out_ch.ready.
// When the row is full a record drops the smallest entry and flags it.
// Synchronous reset empties the table and clears both totals; no clearing
// pass is needed.
`timescale 1ns / 1ps

module sliding_window_event_counter_unit import swec_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  swec_in_if.sink    in_ch,
  swec_out_if.source out_ch
);

`include "sliding_window_event_counter_unit_macros.svh"

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic              busy_r;
  logic              req_r;
  logic [TIME_W-1:0] key_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;
  logic [TIME_W-1:0] rec_r;
  logic [TIME_W-1:0] rec_nxt;
  logic [TIME_W-1:0] qry_r;
  logic [TIME_W-1:0] qry_nxt;

  logic              out_valid_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_drop_r;
  logic [CNT_W-1:0]  out_stored_r;

  logic              in_accept;
  logic              upd_fire;
  logic              full;
  logic [TIME_W-1:0] key_in;
  logic [OCC_W-1:0]  pos;
  logic [OCC_W-1:0]  pos_or;
  logic [OCC_W-1:0]  found;

  swec_nbr_t         cell_q [DEPTH];
  logic [DEPTH-1:0]  hit;

  assign in_ch.ready = !busy_r;
  assign in_accept   = in_ch.valid && !busy_r;
  assign upd_fire    = busy_r && (!out_valid_r || out_ch.ready);
  assign full        = (occ_r == OCC_W'(DEPTH));

  always_comb begin
    if (in_ch.req_type) begin
      key_in = in_ch.now_seconds - in_ch.window_seconds;
    end else if (in_ch.event_time == '0) begin
      key_in = in_ch.now_seconds;
    end else begin
      key_in = in_ch.event_time;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    swec_nbr_t left_d;
    swec_nbr_t right_d;

    if (i == 0) begin : g_head
      assign left_d = '{lt: 1'b1, val: '0};
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '{lt: 1'b0, val: '0};
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end

    swec_cell u_cell (
      .clk        (clk),
      .cmp_en     (in_accept),
      .upd_en     (upd_fire && !req_r),
      .full       (full),
      .head       (i == 0),
      .slot_valid (OCC_W'(i) < occ_r),
      .key_cmp    (key_in),
      .key_ins    (key_r),
      .left       (left_d),
      .right      (right_d),
      .q          (cell_q[i]),
      .hit        (hit[i])
    );
  end

  always_comb begin
    pos_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        pos_or = pos_or | OCC_W'(i);
      end
    end
    pos   = cell_q[DEPTH-1].lt ? OCC_W'(DEPTH) : pos_or;
    found = occ_r - pos;
  end

  always_comb begin
    occ_nxt = occ_r;
    rec_nxt = rec_r;
    qry_nxt = qry_r;
    if (req_r) begin
      qry_nxt = qry_r + TIME_W'(1);
    end else begin
      rec_nxt = rec_r + TIME_W'(1);
      if (!full) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      rec_r       <= '0;
      qry_r       <= '0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (upd_fire) begin
        busy_r <= 1'b0;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        occ_r       <= occ_nxt;
        rec_r       <= rec_nxt;
        qry_r       <= qry_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_ch.req_type;
      key_r <= key_in;
    end
    if (upd_fire) begin
      out_count_r  <= req_r ? CNT_W'(found) : '0;
      out_drop_r   <= !req_r && full;
      out_stored_r <= CNT_W'(occ_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.count_in_window = out_count_r;
  assign out_ch.dropped_oldest  = out_drop_r;
  assign out_ch.stored_entries  = out_stored_r;
  assign out_ch.records_total   = rec_r;
  assign out_ch.queries_total   = qry_r;

  `SWEC_AST_SAME(a_occ_bound, 1'b1, occ_r <= OCC_W'(DEPTH))
  `SWEC_AST_NEXT(a_accept_busy, in_accept, busy_r)
  `SWEC_AST_NEXT(a_update_result, upd_fire, out_valid_r && !busy_r)
  `SWEC_AST_SAME(a_drop_full, out_valid_r && out_drop_r, out_stored_r == CNT_W'(DEPTH))

endmodule

/* hdl/swec_cell.sv */
// One slot of the sorted timestamp row: compare against a key, then shift or insert.
// Depends on swec_pkg.
`timescale 1ns / 1ps

module swec_cell import swec_pkg::*; (
  input  logic              clk,
  input  logic              cmp_en,
  input  logic              upd_en,
  input  logic              full,
  input  logic              head,
  input  logic              slot_valid,
  input  logic [TIME_W-1:0] key_cmp,
  input  logic [TIME_W-1:0] key_ins,
  input  swec_nbr_t         left,
  input  swec_nbr_t         right,
  output swec_nbr_t         q,
  output logic              hit
);

  logic              lt_r;
  logic [TIME_W-1:0] val_r;
  logic [TIME_W-1:0] val_nxt;

  always_comb begin
    if (full) begin
      if (right.lt) begin
        val_nxt = right.val;
      end else if (head || lt_r) begin
        val_nxt = key_ins;
      end else begin
        val_nxt = val_r;
      end
    end else begin
      if (lt_r) begin
        val_nxt = val_r;
      end else if (left.lt) begin
        val_nxt = key_ins;
      end else begin
        val_nxt = left.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt_r <= slot_valid && (val_r < key_cmp);
    end
    if (upd_en) begin
      val_r <= val_nxt;
    end
  end

  assign q   = '{lt: lt_r, val: val_r};
  assign hit = !lt_r && left.lt;

endmodule

/* bench/testbench.sv */
// Self-checking bench for sliding_window_event_counter_unit: requests in, result beats out.
// Results are predicted by a sorted timestamp table kept in a small checker class.
// Depends on swec_pkg, swec_if and the unit under test.
`timescale 1ns / 1ps

typedef enum bit {
  REQ_RECORD = 1'b0,
  REQ_QUERY  = 1'b1
} request_kind_t;

typedef struct packed {
  request_kind_t             kind;
  bit [swec_pkg::TIME_W-1:0] event_time;
  bit [swec_pkg::TIME_W-1:0] now_seconds;
  bit [swec_pkg::TIME_W-1:0] window_seconds;
} window_request_t;

typedef struct packed {
  logic [swec_pkg::CNT_W-1:0]  count_in_window;
  logic                        dropped_oldest;
  logic [swec_pkg::CNT_W-1:0]  stored_entries;
  logic [swec_pkg::TIME_W-1:0] records_total;
  logic [swec_pkg::TIME_W-1:0] queries_total;
} window_result_t;

class window_count_checker;
  int                        depth;
  bit [swec_pkg::TIME_W-1:0] stamps[$];
  bit [swec_pkg::TIME_W-1:0] records_seen;
  bit [swec_pkg::TIME_W-1:0] queries_seen;
  window_result_t            awaited[$];
  int                        mismatches;

  function new(int table_depth);
    depth = table_depth;
  endfunction

  function int first_at_or_above(bit [swec_pkg::TIME_W-1:0] key);
    int idx;
    idx = 0;
    while (idx < stamps.size() && stamps[idx] < key) idx++;
    return idx;
  endfunction

  function void note_request(window_request_t rq);
    window_result_t            want;
    bit [swec_pkg::TIME_W-1:0] stamp;
    int                        n;
    want = '0;
    if (rq.kind == REQ_RECORD) begin
      records_seen++;
      stamp = (rq.event_time == 0) ? rq.now_seconds : rq.event_time;
      if (stamps.size() >= depth) begin
        void'(stamps.pop_front());
        want.dropped_oldest = 1'b1;
      end
      stamps.insert(first_at_or_above(stamp), stamp);
    end else begin
      queries_seen++;
      n = stamps.size() - first_at_or_above(rq.now_seconds - rq.window_seconds);
      want.count_in_window = n[swec_pkg::CNT_W-1:0];
    end
    n = stamps.size();
    want.stored_entries = n[swec_pkg::CNT_W-1:0];
    want.records_total  = records_seen;
    want.queries_total  = queries_seen;
    awaited.push_back(want);
  endfunction

  function void check_result(window_result_t got);
    window_result_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: count %0d dropped %0d stored %0d records %0d queries %0d",
                 got.count_in_window, got.dropped_oldest, got.stored_entries,
                 got.records_total, got.queries_total);
      return;
    end
    want = awaited.pop_front();
    if (want.count_in_window !== got.count_in_window ||
        want.dropped_oldest !== got.dropped_oldest ||
        want.stored_entries !== got.stored_entries ||
        want.records_total !== got.records_total ||
        want.queries_total !== got.queries_total) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t ns", $realtime);
        $display("  expected: count %0d dropped %0d stored %0d records %0d queries %0d",
                 want.count_in_window, want.dropped_oldest, want.stored_entries,
                 want.records_total, want.queries_total);
        $display("  actual:   count %0d dropped %0d stored %0d records %0d queries %0d",
                 got.count_in_window, got.dropped_oldest, got.stored_entries,
                 got.records_total, got.queries_total);
      end
    end
  endfunction

  function int outstanding();
    return awaited.size();
  endfunction
endclass

module testbench;
  import swec_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  logic            clk;
  logic            rst_n;
  bit [TIME_W-1:0] sim_clock;

  window_count_checker board = new(TABLE_DEPTH);

  swec_in_if  in_ch ();
  swec_out_if out_ch ();

  sliding_window_event_counter_unit #(.DEPTH(TABLE_DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic window_request_t pack_request(request_kind_t kind, bit [TIME_W-1:0] ev,
                                                   bit [TIME_W-1:0] now, bit [TIME_W-1:0] win);
    window_request_t rq;
    rq.kind           = kind;
    rq.event_time     = ev;
    rq.now_seconds    = now;
    rq.window_seconds = win;
    return rq;
  endfunction

  // Time mostly creeps forward so that queries land among stored stamps.
  function automatic window_request_t make_random_request(int idx);
    window_request_t rq;
    int              roll;
    int              record_pct;
    int              held;
    record_pct = (idx % 200 < 150) ? 65 : 30;
    held       = board.stamps.size();
    sim_clock  = sim_clock + $urandom_range(0, 6);
    if ($urandom_range(0, 99) < 2) sim_clock = $urandom;
    rq.now_seconds = ($urandom_range(0, 99) < 5) ? $urandom : sim_clock;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < record_pct) begin
      rq.kind           = REQ_RECORD;
      rq.window_seconds = $urandom;
      if (roll < 12) rq.event_time = '0;
      else if (roll < 20) rq.event_time = $urandom;
      else if (roll < 26) rq.event_time = $urandom_range(1, 16);
      else if (roll < 36 && held > 0) rq.event_time = board.stamps[$urandom_range(0, held - 1)];
      else rq.event_time = rq.now_seconds - $urandom_range(0, 120);
    end else begin
      rq.kind       = REQ_QUERY;
      rq.event_time = $urandom;
      if (roll < 15) rq.window_seconds = '0;
      else if (roll < 30) rq.window_seconds = $urandom;
      else if (roll < 42 && held > 0)
        rq.window_seconds = rq.now_seconds - board.stamps[$urandom_range(0, held - 1)];
      else if (roll < 50) rq.window_seconds = rq.now_seconds + $urandom_range(1, 1000);
      else rq.window_seconds = $urandom_range(0, 150);
    end
    return rq;
  endfunction

  task automatic offer_request(window_request_t rq, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= rq.kind;
    in_ch.event_time     <= rq.event_time;
    in_ch.now_seconds    <= rq.now_seconds;
    in_ch.window_seconds <= rq.window_seconds;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(rq);
  endtask

  initial begin : request_source
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= 1'b0;
    in_ch.event_time     <= '0;
    in_ch.now_seconds    <= '0;
    in_ch.window_seconds <= '0;
    rst_n                <= 1'b0;
    sim_clock = 32'hFFFF_FE00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(pack_request(REQ_QUERY, '0, '0, '0), pick_gap());
    offer_request(pack_request(REQ_RECORD, '0, 32'd1000, '0), pick_gap());
    offer_request(pack_request(REQ_RECORD, 32'hFFFF_FFFF, 32'd1000, 32'hFFFF_FFFF), pick_gap());
    offer_request(pack_request(REQ_RECORD, 32'd1, 32'd1000, '0), pick_gap());
    offer_request(pack_request(REQ_RECORD, 32'd1000, 32'd2000, '0), pick_gap());
    offer_request(pack_request(REQ_RECORD, '0, '0, '0), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'd1000, '0), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'd1000, 32'd1000), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'd5, 32'd10), pick_gap());
    offer_request(pack_request(REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, '0, 32'hFFFF_FFFF), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), pick_gap());
    offer_request(pack_request(REQ_RECORD, '0, 32'hFFFF_FFFF, '0), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'd1001, '0), pick_gap());
    offer_request(pack_request(REQ_QUERY, '0, 32'd1, 32'd1), pick_gap());

    for (int i = 0; i < RANDOM_ITEMS; i++)
      offer_request(make_random_request(i), ((i / 64) % 4 == 1) ? 0 : pick_gap());

    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("** sliding_window_event_counter_unit: PASSED **");
    end else begin
      $display("** sliding_window_event_counter_unit: FAILED **");
    end
    $finish;
  end

  // One long hold-off lets the unit fill up and push back on the request side.
  initial begin : result_sink
    window_result_t got;
    int             taken;
    int             idle_left;
    taken     = 0;
    idle_left = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.count_in_window = out_ch.count_in_window;
        got.dropped_oldest  = out_ch.dropped_oldest;
        got.stored_entries  = out_ch.stored_entries;
        got.records_total   = out_ch.records_total;
        got.queries_total   = out_ch.queries_total;
        board.check_result(got);
        taken++;
        if (taken == HOLD_AFTER) idle_left = HOLD_CYCLES;
        else if ((taken / 50) % 3 != 2) idle_left = pick_gap();
      end
      if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("** sliding_window_event_counter_unit: FAILED **");
    $finish;
  end
endmodule
